// ===== hdl/mxt_pkg.sv =====
// Shared types, constants and helpers for the matrix exponential block.
`default_nettype none
package mxt_pkg;
  localparam int DIM_DEF       = 8;
  localparam int MAX_ORDER_DEF = 64;
  localparam int ELEM_W        = 32;
  localparam int VAL_W         = 48;
  localparam int RC_W          = 3;
  localparam int ORD_W         = 7;
  localparam int RCP_W         = 33;
  localparam int ACC_W         = 64;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [ORD_W-1:0]  ORDER_RESET = 7'd32;
  localparam logic [CFG_AW-1:0] ADDR_ORDER  = 3'd0;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam val_t ONE_Q24 = 48'sd16777216;
  localparam val_t VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam val_t VAL_MIN = 48'sh8000_0000_0000;
  localparam acc_t SAT_HI  = 64'sd140737488355327;
  localparam acc_t SAT_LO  = -64'sd140737488355328;
  localparam acc_t RND24   = 64'sd8388608;
  localparam acc_t RND32   = 64'sd2147483648;

  // One A element moving down the cell row
  typedef struct packed {
    logic            vld;
    logic [RC_W-1:0] m;
    logic [RC_W-1:0] j;
    elem_t           a_re;
    elem_t           a_im;
  } tag_t;

  // Broadcast control to all cells
  typedef struct packed {
    logic             init;
    logic             copy;
    logic [RCP_W-1:0] recip;
  } ctl_t;

  // Result read request
  typedef struct packed {
    logic            vld;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
    logic            last;
  } emit_t;

  function automatic logic sat_hit(acc_t x);
    return (x > SAT_HI) || (x < SAT_LO);
  endfunction

  function automatic val_t sat48(acc_t x);
    val_t r;
    if (x > SAT_HI) begin
      r = VAL_MAX;
    end else if (x < SAT_LO) begin
      r = VAL_MIN;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/mxt_in_if.sv =====
// Input channel: one complex matrix element per transfer.
`default_nettype none
interface mxt_in_if;
  import mxt_pkg::*;
  logic  valid;
  logic  ready;
  elem_t elem_re;
  elem_t elem_im;
  logic  last_element;
  modport source (output valid, output elem_re, output elem_im, output last_element,
                  input ready);
  modport sink   (input valid, input elem_re, input elem_im, input last_element,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/mxt_out_if.sv =====
// Result channel: one element of exp(A) per transfer.
`default_nettype none
interface mxt_out_if;
  import mxt_pkg::*;
  logic            valid;
  logic            ready;
  val_t            res_re;
  val_t            res_im;
  logic [RC_W-1:0] row;
  logic [RC_W-1:0] col;
  logic            last_result;
  logic            saturated;
  modport source (output valid, output res_re, output res_im, output row, output col,
                  output last_result, output saturated, input ready);
  modport sink   (input valid, input res_re, input res_im, input row, input col,
                  input last_result, input saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/mxt_cell.sv =====
// Row cell: holds one row of term, next term and sum; complex MAC and 1/k scaling.
`default_nettype none
module mxt_cell #(
  parameter int DIM = mxt_pkg::DIM_DEF,
  parameter int ROW = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mxt_pkg::ctl_t          ctl,
  input  mxt_pkg::tag_t          tag_in,
  output mxt_pkg::tag_t          tag_out,
  input  logic [mxt_pkg::RC_W-1:0] rd_col,
  output mxt_pkg::val_t          rd_re,
  output mxt_pkg::val_t          rd_im,
  output logic                   ovf
);
  import mxt_pkg::*;

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;

  val_t term_re_r [DIM];
  val_t term_im_r [DIM];
  val_t nxt_re_r  [DIM];
  val_t nxt_im_r  [DIM];
  val_t sum_re_r  [DIM];
  val_t sum_im_r  [DIM];

  // stage 0: operand read and split products
  val_t              tr, ti;
  elem_t             ar, ai;
  logic signed [23:0] tr_hi, ti_hi;
  logic signed [24:0] tr_lo, ti_lo;

  assign tr    = term_re_r[tag_in.m[IW-1:0]];
  assign ti    = term_im_r[tag_in.m[IW-1:0]];
  assign ar    = tag_in.a_re;
  assign ai    = tag_in.a_im;
  assign tr_hi = tr[VAL_W-1:24];
  assign ti_hi = ti[VAL_W-1:24];
  assign tr_lo = {1'b0, tr[23:0]};
  assign ti_lo = {1'b0, ti[23:0]};

  // product order: tr*ar, ti*ai, tr*ai, ti*ar
  logic signed [55:0] s1_h_r [4];
  logic signed [56:0] s1_l_r [4];
  logic               s1_vld_r, s1_first_r, s1_last_r;

  always_ff @(posedge clk) begin
    s1_h_r[0] <= tr_hi * ar;
    s1_l_r[0] <= tr_lo * ar;
    s1_h_r[1] <= ti_hi * ai;
    s1_l_r[1] <= ti_lo * ai;
    s1_h_r[2] <= tr_hi * ai;
    s1_l_r[2] <= tr_lo * ai;
    s1_h_r[3] <= ti_hi * ar;
    s1_l_r[3] <= ti_lo * ar;
  end

  logic [RC_W-1:0] s1_j_r, s2_j_r, s3_j_r, s4_j_r, s5_j_r, s6_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      tag_out.vld <= 1'b0;
    end else begin
      s1_vld_r    <= tag_in.vld;
      tag_out.vld <= tag_in.vld;
    end
    s1_first_r   <= (tag_in.m == '0);
    s1_last_r    <= (tag_in.m == RC_W'(DIM - 1));
    s1_j_r       <= tag_in.j;
    tag_out.m    <= tag_in.m;
    tag_out.j    <= tag_in.j;
    tag_out.a_re <= tag_in.a_re;
    tag_out.a_im <= tag_in.a_im;
  end

  // stage 2: rounded partial products
  acc_t s2_mr_r [4];
  logic s2_vld_r, s2_first_r, s2_last_r;

  always_ff @(posedge clk) begin
    for (int q = 0; q < 4; q++) begin
      s2_mr_r[q] <= acc_t'(s1_h_r[q]) + ((acc_t'(s1_l_r[q]) + RND24) >>> 24);
    end
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_j_r     <= s1_j_r;
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  // stage 3: accumulate over m
  acc_t val_re, val_im;
  acc_t acc_re_r, acc_im_r;
  logic s3_done_r;

  assign val_re = s2_mr_r[0] - s2_mr_r[1];
  assign val_im = s2_mr_r[2] + s2_mr_r[3];

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      acc_re_r <= s2_first_r ? val_re : acc_re_r + val_re;
      acc_im_r <= s2_first_r ? val_im : acc_im_r + val_im;
      s3_j_r   <= s2_j_r;
    end
    if (!rst_n) begin
      s3_done_r <= 1'b0;
    end else begin
      s3_done_r <= s2_vld_r && s2_last_r;
    end
  end

  // stage 4: saturate the row-column sum
  val_t s4_re_r, s4_im_r;
  logic s4_vld_r;

  always_ff @(posedge clk) begin
    s4_re_r <= sat48(acc_re_r);
    s4_im_r <= sat48(acc_im_r);
    s4_j_r  <= s3_j_r;
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_done_r;
    end
  end

  // stage 5: scale by 1/k
  logic signed [RCP_W:0] rs;
  logic signed [24:0]    re_lo, im_lo;
  logic signed [23:0]    re_hi, im_hi;
  logic signed [57:0]    s5_hre_r, s5_him_r;
  logic signed [58:0]    s5_lre_r, s5_lim_r;
  logic                  s5_vld_r;

  assign rs    = {1'b0, ctl.recip};
  assign re_hi = s4_re_r[VAL_W-1:24];
  assign im_hi = s4_im_r[VAL_W-1:24];
  assign re_lo = {1'b0, s4_re_r[23:0]};
  assign im_lo = {1'b0, s4_im_r[23:0]};

  always_ff @(posedge clk) begin
    s5_hre_r <= re_hi * rs;
    s5_lre_r <= re_lo * rs;
    s5_him_r <= im_hi * rs;
    s5_lim_r <= im_lo * rs;
    s5_j_r   <= s4_j_r;
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  // stage 6: rounded next term
  acc_t nt_re, nt_im;
  val_t s6_re_r, s6_im_r;
  logic s6_vld_r;

  assign nt_re = (acc_t'(s5_hre_r) + ((acc_t'(s5_lre_r) + RND32) >>> 24)) >>> 8;
  assign nt_im = (acc_t'(s5_him_r) + ((acc_t'(s5_lim_r) + RND32) >>> 24)) >>> 8;

  always_ff @(posedge clk) begin
    s6_re_r <= nt_re[VAL_W-1:0];
    s6_im_r <= nt_im[VAL_W-1:0];
    s6_j_r  <= s5_j_r;
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  // write back
  acc_t sum_re_nxt, sum_im_nxt;
  assign sum_re_nxt = acc_t'(sum_re_r[s6_j_r[IW-1:0]]) + acc_t'(s6_re_r);
  assign sum_im_nxt = acc_t'(sum_im_r[s6_j_r[IW-1:0]]) + acc_t'(s6_im_r);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int c = 0; c < DIM; c++) begin
        term_re_r[c] <= (c == ROW) ? ONE_Q24 : '0;
        term_im_r[c] <= '0;
        sum_re_r[c]  <= (c == ROW) ? ONE_Q24 : '0;
        sum_im_r[c]  <= '0;
      end
    end else if (ctl.copy) begin
      for (int c = 0; c < DIM; c++) begin
        term_re_r[c] <= nxt_re_r[c];
        term_im_r[c] <= nxt_im_r[c];
      end
    end else if (s6_vld_r) begin
      nxt_re_r[s6_j_r[IW-1:0]] <= s6_re_r;
      nxt_im_r[s6_j_r[IW-1:0]] <= s6_im_r;
      sum_re_r[s6_j_r[IW-1:0]] <= sat48(sum_re_nxt);
      sum_im_r[s6_j_r[IW-1:0]] <= sat48(sum_im_nxt);
    end
  end

  logic ovf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (ctl.init) begin
      ovf_r <= 1'b0;
    end else if ((s3_done_r && (sat_hit(acc_re_r) || sat_hit(acc_im_r))) ||
                 (s6_vld_r && (sat_hit(sum_re_nxt) || sat_hit(sum_im_nxt)))) begin
      ovf_r <= 1'b1;
    end
  end

  assign ovf   = ovf_r;
  assign rd_re = sum_re_r[rd_col[IW-1:0]];
  assign rd_im = sum_im_r[rd_col[IW-1:0]];
endmodule
`default_nettype wire

// ===== hdl/mxt_seq.sv =====
// Sequencer: matrix load memory, A stream feeder, order loop and result readout.
`default_nettype none
module mxt_seq #(
  parameter int DIM       = mxt_pkg::DIM_DEF,
  parameter int MAX_ORDER = mxt_pkg::MAX_ORDER_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mxt_in_if.sink                    in_ch,
  input  logic [mxt_pkg::ORD_W-1:0] order,
  input  logic                      out_free,
  output mxt_pkg::ctl_t             ctl,
  output mxt_pkg::tag_t             tag,
  output mxt_pkg::emit_t            em
);
  import mxt_pkg::*;

  localparam int NELEM     = DIM * DIM;
  localparam int IW        = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int EW        = (NELEM > 1) ? $clog2(NELEM) : 1;
  localparam int LW        = $clog2(NELEM + 1);
  localparam int KW        = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int DRAIN_LEN = DIM + 10;
  localparam int DW        = $clog2(DRAIN_LEN);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_FEED  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_COPY  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // reciprocal table, unsigned Q1.32
  logic [RCP_W-1:0] rtab [MAX_ORDER + 1];
  assign rtab[0] = '0;
  for (genvar g = 1; g <= MAX_ORDER; g++) begin : g_rcp
    localparam longint unsigned RV = ((64'd1 << 32) + g / 2) / g;
    assign rtab[g] = RCP_W'(RV);
  end

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] load_idx_r, load_idx_nxt;
  logic [KW-1:0] k_r, k_nxt, ord_r, ord_nxt, ord_clamp;
  logic [IW-1:0] m_r, m_nxt, j_r, j_nxt, r_r, r_nxt, c_r, c_nxt;
  logic [DW-1:0] drn_r, drn_nxt;
  logic          feed, em_vld, acc_in, we;
  logic [EW-1:0] raddr;

  logic [2*ELEM_W-1:0] mem [NELEM];
  logic [2*ELEM_W-1:0] rd_r;
  logic                tag_vld_r;
  logic [RC_W-1:0]     tag_m_r, tag_j_r;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign acc_in      = in_ch.valid && (state_r == ST_LOAD);
  assign we          = acc_in && (load_idx_r < LW'(NELEM));
  assign raddr       = EW'(int'(m_r) * DIM + int'(j_r));
  assign ord_clamp   = (int'(order) > MAX_ORDER) ? KW'(MAX_ORDER) : KW'(order);

  always_comb begin
    state_nxt    = state_r;
    load_idx_nxt = load_idx_r;
    k_nxt        = k_r;
    ord_nxt      = ord_r;
    m_nxt        = m_r;
    j_nxt        = j_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    drn_nxt      = drn_r;
    feed         = 1'b0;
    em_vld       = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (acc_in) begin
          if (we) begin
            load_idx_nxt = load_idx_r + 1'b1;
          end
          if (in_ch.last_element) begin
            load_idx_nxt = '0;
            state_nxt    = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        ord_nxt   = ord_clamp;
        k_nxt     = KW'(1);
        m_nxt     = '0;
        j_nxt     = '0;
        r_nxt     = '0;
        c_nxt     = '0;
        state_nxt = (ord_clamp == '0) ? ST_OUT : ST_FEED;
      end
      ST_FEED: begin
        feed = 1'b1;
        if (m_r == IW'(DIM - 1)) begin
          m_nxt = '0;
          if (j_r == IW'(DIM - 1)) begin
            j_nxt     = '0;
            drn_nxt   = '0;
            state_nxt = ST_DRAIN;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drn_r == DW'(DRAIN_LEN - 1)) begin
          state_nxt = ST_COPY;
        end else begin
          drn_nxt = drn_r + 1'b1;
        end
      end
      ST_COPY: begin
        if (k_r == ord_r) begin
          state_nxt = ST_OUT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_FEED;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          em_vld = 1'b1;
          if (c_r == IW'(DIM - 1)) begin
            c_nxt = '0;
            if (r_r == IW'(DIM - 1)) begin
              r_nxt     = '0;
              state_nxt = ST_LOAD;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_idx_r <= '0;
      k_r        <= '0;
      ord_r      <= '0;
      m_r        <= '0;
      j_r        <= '0;
      r_r        <= '0;
      c_r        <= '0;
      drn_r      <= '0;
      tag_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_idx_r <= load_idx_nxt;
      k_r        <= k_nxt;
      ord_r      <= ord_nxt;
      m_r        <= m_nxt;
      j_r        <= j_nxt;
      r_r        <= r_nxt;
      c_r        <= c_nxt;
      drn_r      <= drn_nxt;
      tag_vld_r  <= feed;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[load_idx_r[EW-1:0]] <= {in_ch.elem_re, in_ch.elem_im};
    end
    rd_r    <= mem[raddr];
    tag_m_r <= RC_W'(m_r);
    tag_j_r <= RC_W'(j_r);
  end

  assign tag.vld  = tag_vld_r;
  assign tag.m    = tag_m_r;
  assign tag.j    = tag_j_r;
  assign tag.a_re = rd_r[2*ELEM_W-1:ELEM_W];
  assign tag.a_im = rd_r[ELEM_W-1:0];

  assign ctl.init  = (state_r == ST_INIT);
  assign ctl.copy  = (state_r == ST_COPY);
  assign ctl.recip = rtab[k_r];

  assign em.vld  = em_vld;
  assign em.row  = RC_W'(r_r);
  assign em.col  = RC_W'(c_r);
  assign em.last = (r_r == IW'(DIM - 1)) && (c_r == IW'(DIM - 1));
endmodule
`default_nettype wire

// ===== hdl/matrix_exponential_taylor.sv =====
// Top level: complex matrix exponential by truncated Taylor series.
// Elements of A are taken one per transfer in row-major order; the transfer
// with last_element set starts the computation. The series runs as
// T_k = T_{k-1}*A/k on a row of DIM cells, one per matrix row, with A streamed
// down the row from a DIM*DIM element memory one element per cycle. Each of
// the n = min(order_in_use, MAX_ORDER) terms takes a stream, a pipeline drain
// and a term copy, and a matrix yields DIM*DIM result transfers; no input is
// taken from the last mark until the final result is handed to the output
// register. order_in_use is at byte address 0.
`default_nettype none
module matrix_exponential_taylor #(
  parameter int DIM       = mxt_pkg::DIM_DEF,
  parameter int MAX_ORDER = mxt_pkg::MAX_ORDER_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mxt_in_if.sink                     in_ch,
  mxt_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [mxt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mxt_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mxt_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import mxt_pkg::*;

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;

  // configuration
  logic [ORD_W-1:0] order_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_ORDER);
  assign cfg_prdata = (cfg_paddr == ADDR_ORDER) ? CFG_DW'(order_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_wr) begin
      order_r <= cfg_pwdata[ORD_W-1:0];
    end
  end

  // sequencer and cell row
  ctl_t     ctl;
  emit_t    em;
  tag_t     chain [DIM + 1];
  val_t     cell_re [DIM];
  val_t     cell_im [DIM];
  logic [DIM-1:0] cell_ovf;
  logic     out_vld_r, out_free;

  assign out_free = !out_vld_r || out_ch.ready;

  mxt_seq #(.DIM(DIM), .MAX_ORDER(MAX_ORDER)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .order    (order_r),
    .out_free (out_free),
    .ctl      (ctl),
    .tag      (chain[0]),
    .em       (em)
  );

  for (genvar i = 0; i < DIM; i++) begin : g_cell
    mxt_cell #(.DIM(DIM), .ROW(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .tag_in  (chain[i]),
      .tag_out (chain[i+1]),
      .rd_col  (em.col),
      .rd_re   (cell_re[i]),
      .rd_im   (cell_im[i]),
      .ovf     (cell_ovf[i])
    );
  end

  // output register
  val_t            res_re_r, res_im_r;
  logic [RC_W-1:0] row_r, col_r;
  logic            last_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (em.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (em.vld) begin
      res_re_r <= cell_re[em.row[IW-1:0]];
      res_im_r <= cell_im[em.row[IW-1:0]];
      row_r    <= em.row;
      col_r    <= em.col;
      last_r   <= em.last;
      sat_r    <= |cell_ovf;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.res_re      = res_re_r;
  assign out_ch.res_im      = res_im_r;
  assign out_ch.row         = row_r;
  assign out_ch.col         = col_r;
  assign out_ch.last_result = last_r;
  assign out_ch.saturated   = sat_r;

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    em.vld |-> (!out_vld_r || out_ch.ready))
    else $error("result issued while output register is full");

  a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !em.vld)
    else $error("input accepted during result readout");

  a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (em.vld && em.last) |=> in_ch.ready)
    else $error("input not reopened after final result");
endmodule
`default_nettype wire

// ===== tb/matrix_exponential_taylor_checker.sv =====
// Checker: tracks loaded matrices, predicts exp(A) and compares each result transfer.
`default_nettype none
module matrix_exponential_taylor_checker
  import mxt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mxt_in_if                    in_ch,
  mxt_out_if                   out_ch,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic                 cfg_pready,
  input  logic [CFG_AW-1:0]    cfg_paddr,
  input  logic [CFG_DW-1:0]    cfg_pwdata,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N  = DIM_DEF;
  localparam int NN = N * N;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    val_t            re;
    val_t            im;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
    logic            last;
    logic            sat;
  } exp_elem_t;

  elem_t           mat_re [NN];
  elem_t           mat_im [NN];
  val_t            term_re [NN], term_im [NN];
  val_t            nxt_re [NN], nxt_im [NN];
  val_t            sum_re [NN], sum_im [NN];
  int              load_idx;
  logic [ORD_W-1:0] order;
  bit              sat_seen;
  exp_elem_t       exp_q [$];

  function automatic wide_t rmul(wide_t a, wide_t b, int frac);
    wide_t p;
    p = a * b + (wide_t'(1) <<< (frac - 1));
    return p >>> frac;
  endfunction

  function automatic val_t clip(wide_t x);
    if (x > wide_t'(VAL_MAX)) begin
      sat_seen = 1;
      return VAL_MAX;
    end
    if (x < wide_t'(VAL_MIN)) begin
      sat_seen = 1;
      return VAL_MIN;
    end
    return val_t'(x);
  endfunction

  task automatic predict_exp();
    int    ord;
    wide_t rcp, acc_re, acc_im;
    val_t  id;
    exp_elem_t x;
    ord = (order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : int'(order);
    sat_seen = 0;
    for (int e = 0; e < NN; e++) begin
      id = (e / N == e % N) ? ONE_Q24 : '0;
      term_re[e] = val_t'(mat_re[e]);
      term_im[e] = val_t'(mat_im[e]);
      if (ord == 0) begin
        sum_re[e] = id;
        sum_im[e] = '0;
      end else begin
        sum_re[e] = val_t'(mat_re[e]) + id;
        sum_im[e] = val_t'(mat_im[e]);
      end
    end
    for (int k = 2; k <= ord; k++) begin
      rcp = ((wide_t'(1) <<< 32) + wide_t'(k / 2)) / wide_t'(k);
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          acc_re = 0;
          acc_im = 0;
          for (int m = 0; m < N; m++) begin
            acc_re += rmul(term_re[i*N+m], mat_re[m*N+j], 24)
                    - rmul(term_im[i*N+m], mat_im[m*N+j], 24);
            acc_im += rmul(term_re[i*N+m], mat_im[m*N+j], 24)
                    + rmul(term_im[i*N+m], mat_re[m*N+j], 24);
          end
          nxt_re[i*N+j] = val_t'(rmul(clip(acc_re), rcp, 32));
          nxt_im[i*N+j] = val_t'(rmul(clip(acc_im), rcp, 32));
        end
      end
      for (int e = 0; e < NN; e++) begin
        term_re[e] = nxt_re[e];
        term_im[e] = nxt_im[e];
        sum_re[e]  = clip(wide_t'(sum_re[e]) + wide_t'(term_re[e]));
        sum_im[e]  = clip(wide_t'(sum_im[e]) + wide_t'(term_im[e]));
      end
    end
    for (int e = 0; e < NN; e++) begin
      x.re   = sum_re[e];
      x.im   = sum_im[e];
      x.row  = RC_W'(e / N);
      x.col  = RC_W'(e % N);
      x.last = (e == NN - 1);
      x.sat  = sat_seen;
      exp_q.push_back(x);
    end
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 40) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
    end
  endtask

  initial begin
    errors   = 0;
    pending  = 0;
    load_idx = 0;
    order    = ORDER_RESET;
  end

  always @(posedge clk) begin
    exp_elem_t x;
    if (rst_n) begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_ORDER) begin
        order = cfg_pwdata[ORD_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        if (exp_q.size() == 0) begin
          errors++;
          if (errors <= 40) begin
            $display("%0t unexpected result transfer row %0d col %0d", $time,
                     out_ch.row, out_ch.col);
          end
        end else begin
          x = exp_q.pop_front();
          if (out_ch.res_re !== x.re) report("res_re", 64'(x.re), 64'(out_ch.res_re));
          if (out_ch.res_im !== x.im) report("res_im", 64'(x.im), 64'(out_ch.res_im));
          if (out_ch.row !== x.row) report("row", 64'(x.row), 64'(out_ch.row));
          if (out_ch.col !== x.col) report("col", 64'(x.col), 64'(out_ch.col));
          if (out_ch.last_result !== x.last) begin
            report("last_result", 64'(x.last), 64'(out_ch.last_result));
          end
          if (out_ch.saturated !== x.sat) report("saturated", 64'(x.sat), 64'(out_ch.saturated));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (load_idx < NN) begin
          mat_re[load_idx] = in_ch.elem_re;
          mat_im[load_idx] = in_ch.elem_im;
          load_idx++;
        end
        if (in_ch.last_element) begin
          predict_exp();
          load_idx = 0;
        end
      end
    end
    pending <= exp_q.size();
  end
endmodule
`default_nettype wire

// ===== tb/matrix_exponential_taylor_test.sv =====
// Testbench top: drives matrices and order settings, applies back-pressure, gives the verdict.
`default_nettype none
module matrix_exponential_taylor_test;
  import mxt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NN        = DIM_DEF * DIM_DEF;
  localparam int NUM_ITEMS = 310;
  localparam int HOLD_LEN  = 3000;
  localparam int WD_LIMIT  = 40000;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  int                errors, pending;
  int                sent;
  int                idle_cycles;
  bit                calm;
  bit                hold_go;

  mxt_in_if  in_ch ();
  mxt_out_if out_ch ();

  matrix_exponential_taylor DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  matrix_exponential_taylor_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic elem_t pick_elem(bit wild);
    int r;
    r = $urandom_range(0, 9);
    if (wild && r < 4) return elem_t'($urandom);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return '0;
        default: return -32'sd1;
      endcase
    end
    return elem_t'($urandom) >>> $urandom_range(wild ? 4 : 9, 31);
  endfunction

  task automatic put_elem(elem_t re, elem_t im, logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.elem_re      <= re;
    in_ch.elem_im      <= im;
    in_ch.last_element <= lst;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent++;
  endtask

  task automatic put_matrix(int len, bit wild);
    for (int n = 0; n < len; n++) begin
      put_elem(pick_elem(wild), pick_elem(wild), n == len - 1);
    end
  endtask

  task automatic write_order(int value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_ORDER;
    cfg_pwdata  <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int gap;
    bit held;
    held = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go && !held) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WD_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WD_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int r, len;
    bit wild;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.elem_re      <= '0;
    in_ch.elem_im      <= '0;
    in_ch.last_element <= 1'b0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    idle_cycles        <= 0;
    calm    = 0;
    hold_go = 0;
    sent    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full first load, then early last marks with extreme values
    write_order(1);
    put_matrix(NN, 0);
    put_elem(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    put_elem(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    put_elem('0, '0, 1'b0);
    put_elem(-32'sd1, -32'sd1, 1'b1);
    drain();
    write_order(0);
    put_elem(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    drain();
    write_order(127);
    put_elem(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    drain();
    write_order(64);
    put_elem(32'sd1, -32'sd1, 1'b1);
    drain();

    // random phases
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        r = $urandom_range(0, 9);
        case (r)
          0: write_order(0);
          1: write_order(1);
          2: write_order(127);
          3: write_order(64);
          default: write_order($urandom_range(2, 12));
        endcase
      end
      calm = ($urandom_range(0, 3) == 0);
      wild = ($urandom_range(0, 4) == 0);
      if (!hold_go && sent >= 100) begin
        write_order(2);
        hold_go = 1;
        put_matrix(NN, 0);
        put_matrix(NN, 0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) len = NN;
        else if (r < 85) len = $urandom_range(1, NN - 1);
        else len = NN + $urandom_range(1, 6);
        put_matrix(len, wild);
      end
      drain();
    end
    calm = 0;

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/mxt_pkg.sv
hdl/mxt_in_if.sv
hdl/mxt_out_if.sv
hdl/mxt_cell.sv
hdl/mxt_seq.sv
hdl/matrix_exponential_taylor.sv
tb/matrix_exponential_taylor_checker.sv
tb/matrix_exponential_taylor_test.sv
